### rtl/hash_join_build_probe_unit_defines.svh
// Assertion macros used by the hash join RTL.
`ifndef HASH_JOIN_BUILD_PROBE_UNIT_DEFINES_SVH
`define HASH_JOIN_BUILD_PROBE_UNIT_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define HJB_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hjb assertion failed");

// Next-cycle implication, checked out of reset.
`define HJB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hjb assertion failed");

`endif

### rtl/hjb_pkg.sv
// Package with transaction types and action codes of the hash join unit.
package hjb_pkg;

  localparam int unsigned ACTION_W = 2;
  localparam int unsigned KEY_W    = 32;
  localparam int unsigned COUNT_W  = 11;
  localparam int unsigned MATCH_W  = 11;
  localparam int unsigned TOTAL_W  = 32;

  localparam logic [ACTION_W-1:0] ACT_BEGIN = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_BUILD = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_PROBE = 2'd2;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [KEY_W-1:0]    key;
    logic [COUNT_W-1:0]  inner_count;
    logic                is_last;
  } in_t;

  typedef struct packed {
    logic [MATCH_W-1:0] probe_matches;
    logic [TOTAL_W-1:0] total_matches;
    logic               partition_done;
    logic               error;
  } out_t;

endpackage

### rtl/hjb_ram.sv
// Generic simple dual-port RAM with registered read.
module hjb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### rtl/hash_join_build_probe_unit.sv
// Top level of the bucket-chained hash join build/probe unit.
//
// Usage: drive in_data and raise start; the command transaction is taken at
// a clock edge where start is high and busy is low. Exactly one result per
// command appears on out_data for one cycle, marked by out_valid; there is
// no back-pressure on the result side.
// Steps from the accepting edge to the out_valid cycle:
//   begin : head-table rows 0 to bucket_mask cleared, one row per cycle
//   build : head read, then head and entry write
//   probe : result registered directly into an empty table, else head read,
//           then one entry-memory read per chain link
//   other : result registered directly (refused builds, unused action code)
// busy stays high until the result is launched; the next command may be
// taken in the cycle where out_valid is shown. A build keeps busy high
// through its write state; probes wait on an entry memory read per link.
// Reset (synchronous, rst_n low) empties the unit: no entries, mask 0,
// running total 0. Heads are cleared by each begin only over the buckets
// that partition uses; probes before any build return zero matches.
`include "hash_join_build_probe_unit_defines.svh"

module hash_join_build_probe_unit #(
  parameter int unsigned TABLE_DEPTH = 1024,
  parameter int unsigned KEY_BITS    = 32
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  hjb_pkg::in_t   in_data,
  output logic           out_valid,
  output hjb_pkg::out_t  out_data
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned PW = AW + 1;
  localparam int unsigned KW = (KEY_BITS < hjb_pkg::KEY_W) ? KEY_BITS : hjb_pkg::KEY_W;
  localparam int unsigned CW = (PW > hjb_pkg::COUNT_W) ? PW : hjb_pkg::COUNT_W;
  localparam int unsigned EW = KW + PW;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CLEAR = 3'd1;
  localparam logic [2:0] S_BUILD = 3'd2;
  localparam logic [2:0] S_HEAD  = 3'd3;
  localparam logic [2:0] S_WALK  = 3'd4;

  // control state
  logic [2:0]                    state_r, state_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [PW-1:0]                 entries_built_r, entries_built_nxt;
  logic [PW-1:0]                 declared_r, declared_nxt;
  logic [AW-1:0]                 mask_r, mask_nxt;
  logic [hjb_pkg::TOTAL_W-1:0]   total_r, total_nxt;
  logic [AW-1:0]                 clr_r, clr_nxt;

  // payload
  logic [KW-1:0]                 item_key_r, item_key_nxt;
  logic [AW-1:0]                 bkt_r, bkt_nxt;
  logic                          last_r, last_nxt;
  logic [hjb_pkg::MATCH_W-1:0]   match_cnt_r, match_cnt_nxt;
  hjb_pkg::out_t                 out_r, out_nxt;

  // memory ports
  logic                          head_we;
  logic [AW-1:0]                 head_waddr;
  logic [PW-1:0]                 head_wdata;
  logic [AW-1:0]                 head_raddr;
  logic [PW-1:0]                 head_rdata;
  logic                          ent_we;
  logic [AW-1:0]                 ent_waddr;
  logic [EW-1:0]                 ent_wdata;
  logic [AW-1:0]                 ent_raddr;
  logic [EW-1:0]                 ent_rdata;
  logic                          ent_rd_en;

  // datapath helpers
  logic [KW-1:0]                 key_in;
  logic [AW+KW-1:0]              key_pad;
  logic [AW-1:0]                 bucket_in;
  logic [CW-1:0]                 cnt_ext;
  logic [CW-1:0]                 decl_c;
  logic [PW-1:0]                 decl_w;
  logic [PW-1:0]                 decl_m1;
  logic [AW-1:0]                 mask_calc;
  logic [KW-1:0]                 ent_key;
  logic [PW-1:0]                 ent_link;
  logic [PW-1:0]                 ptr_sel;
  logic [PW-1:0]                 ptr_m1;
  logic [hjb_pkg::MATCH_W-1:0]   cnt_inc;
  logic [hjb_pkg::MATCH_W-1:0]   fin_cnt;
  logic [hjb_pkg::TOTAL_W:0]     sum_w;
  logic [hjb_pkg::TOTAL_W-1:0]   total_sat;

  // key and bucket of the incoming command
  assign key_in    = in_data.key[KW-1:0];
  assign key_pad   = {{AW{1'b0}}, key_in};
  assign bucket_in = key_pad[AW-1:0] & mask_r;

  // declared count clamped to capacity, mask = next power of two minus one
  assign cnt_ext = CW'(in_data.inner_count);
  assign decl_c  = (cnt_ext > CW'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : cnt_ext;
  assign decl_w  = decl_c[PW-1:0];
  assign decl_m1 = decl_w - PW'(1);

  always_comb begin
    logic acc;
    acc = 1'b0;
    for (int i = AW - 1; i >= 0; i--) begin
      acc          = acc | decl_m1[i];
      mask_calc[i] = acc & (decl_w != '0);
    end
  end

  // entry memory word: key above, chain link below
  assign ent_key  = ent_rdata[EW-1:PW];
  assign ent_link = ent_rdata[PW-1:0];

  // next chain pointer: head word in HEAD, link word in WALK
  assign ptr_sel   = (state_r == S_HEAD) ? head_rdata : ent_link;
  assign ptr_m1    = ptr_sel - PW'(1);
  assign ent_raddr = ptr_m1[AW-1:0];
  assign cnt_inc   = match_cnt_r + hjb_pkg::MATCH_W'(ent_key == item_key_r);

  // saturating running total for the finishing probe
  assign fin_cnt   = (state_r == S_WALK) ? cnt_inc : match_cnt_r;
  assign sum_w     = {1'b0, total_r} + (hjb_pkg::TOTAL_W + 1)'(fin_cnt);
  assign total_sat = sum_w[hjb_pkg::TOTAL_W] ? hjb_pkg::TOTAL_MAX
                                             : sum_w[hjb_pkg::TOTAL_W-1:0];

  // sequencer
  always_comb begin
    state_nxt         = state_r;
    out_valid_nxt     = 1'b0;
    entries_built_nxt = entries_built_r;
    declared_nxt      = declared_r;
    mask_nxt          = mask_r;
    total_nxt         = total_r;
    clr_nxt           = clr_r;
    item_key_nxt      = item_key_r;
    bkt_nxt           = bkt_r;
    last_nxt          = last_r;
    match_cnt_nxt     = match_cnt_r;
    out_nxt           = out_r;

    head_we    = 1'b0;
    head_waddr = clr_r;
    head_wdata = '0;
    head_raddr = bucket_in;
    ent_we     = 1'b0;
    ent_waddr  = entries_built_r[AW-1:0];
    ent_wdata  = {item_key_r, head_rdata};
    ent_rd_en  = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          item_key_nxt  = key_in;
          bkt_nxt       = bucket_in;
          last_nxt      = in_data.is_last;
          match_cnt_nxt = '0;
          out_nxt       = '{probe_matches: '0, total_matches: total_r,
                            partition_done: 1'b0, error: 1'b0};
          case (in_data.action)
            hjb_pkg::ACT_BEGIN: begin
              declared_nxt      = decl_w;
              mask_nxt          = mask_calc;
              entries_built_nxt = '0;
              clr_nxt           = '0;
              state_nxt         = S_CLEAR;
            end
            hjb_pkg::ACT_BUILD: begin
              if (entries_built_r >= declared_r) begin
                out_nxt.error = 1'b1;
                out_valid_nxt = 1'b1;
              end else begin
                state_nxt = S_BUILD;
              end
            end
            hjb_pkg::ACT_PROBE: begin
              if (entries_built_r == '0) begin
                out_nxt.partition_done = in_data.is_last;
                out_valid_nxt          = 1'b1;
              end else begin
                state_nxt = S_HEAD;
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end

      // zero one head row per cycle over the buckets in use
      S_CLEAR: begin
        head_we = 1'b1;
        clr_nxt = clr_r + AW'(1);
        if (clr_r == mask_r) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      // push the new entry onto its bucket chain
      S_BUILD: begin
        head_we           = 1'b1;
        head_waddr        = bkt_r;
        head_wdata        = entries_built_r + PW'(1);
        ent_we            = 1'b1;
        entries_built_nxt = entries_built_r + PW'(1);
        out_valid_nxt     = 1'b1;
        state_nxt         = S_IDLE;
      end

      // chain head arrived; start the walk or finish on an empty bucket
      S_HEAD: begin
        if (head_rdata == '0) begin
          total_nxt     = total_sat;
          out_nxt       = '{probe_matches: fin_cnt, total_matches: total_sat,
                            partition_done: last_r, error: 1'b0};
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          ent_rd_en = 1'b1;
          state_nxt = S_WALK;
        end
      end

      // one chain entry per cycle
      S_WALK: begin
        match_cnt_nxt = cnt_inc;
        if (ent_link == '0) begin
          total_nxt     = total_sat;
          out_nxt       = '{probe_matches: fin_cnt, total_matches: total_sat,
                            partition_done: last_r, error: 1'b0};
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          ent_rd_en = 1'b1;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      out_valid_r     <= 1'b0;
      entries_built_r <= '0;
      declared_r      <= '0;
      mask_r          <= '0;
      total_r         <= '0;
      clr_r           <= '0;
    end else begin
      state_r         <= state_nxt;
      out_valid_r     <= out_valid_nxt;
      entries_built_r <= entries_built_nxt;
      declared_r      <= declared_nxt;
      mask_r          <= mask_nxt;
      total_r         <= total_nxt;
      clr_r           <= clr_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    item_key_r  <= item_key_nxt;
    bkt_r       <= bkt_nxt;
    last_r      <= last_nxt;
    match_cnt_r <= match_cnt_nxt;
    out_r       <= out_nxt;
  end

  // bucket head table: entry number plus one, zero for empty
  hjb_ram #(
    .WIDTH (PW),
    .DEPTH (TABLE_DEPTH)
  ) u_head_ram (
    .clk   (clk),
    .we    (head_we),
    .waddr (head_waddr),
    .wdata (head_wdata),
    .raddr (head_raddr),
    .rdata (head_rdata)
  );

  // entry table: stored key and chain link
  hjb_ram #(
    .WIDTH (EW),
    .DEPTH (TABLE_DEPTH)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (ent_waddr),
    .wdata (ent_wdata),
    .raddr (ent_raddr),
    .rdata (ent_rdata)
  );

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // checks
  `HJB_ASSERT_IMP(a_built_le_decl, 1'b1, entries_built_r <= declared_r)
  `HJB_ASSERT_IMP(a_walk_in_range, ent_rd_en, ent_raddr < entries_built_r)
  `HJB_ASSERT_IMP(a_err_clean, out_valid_r && out_r.error, (out_r.probe_matches == '0) && !out_r.partition_done)
  `HJB_ASSERT_NEXT(a_total_mono, 1'b1, total_r >= $past(total_r))

endmodule
